// File: design/lpbq_pkg.sv
// Shared types, constants and helper functions of the lowpass biquad coefficient calculator.
package lpbq_pkg;

	localparam int COEF_WIDTH   = 32;
	localparam int CORDIC_STEPS = 24;
	localparam int COR_CW       = $clog2(CORDIC_STEPS);
	localparam int DIV_W        = 64;
	localparam int DSR_W        = 40;
	localparam int DIV_STEPS    = DIV_W;
	localparam int DIV_CW       = $clog2(DIV_STEPS);
	localparam int VAL_W        = 41;
	localparam int CS_W         = 34;

	localparam logic [20:0] MIN_CUTOFF    = 21'd320;
	localparam logic [17:0] RST_FS        = 18'd48000;
	localparam logic [22:0] RST_Q         = 23'd46341;
	localparam logic        RST_NORM      = 1'b1;
	localparam logic [31:0] PI_Q30        = 32'd3373259426;
	localparam logic signed [CS_W-1:0]  CORDIC_GAIN = 34'sh026DD3B6A;
	localparam logic signed [VAL_W-1:0] ONE_Q30     = 41'sd1073741824;
	localparam logic [DIV_W-1:0]        ALPHA_LIMIT = 64'h0000_0040_0000_0000;
	localparam logic signed [64:0]      UNITY_Q24   = 65'sd16777216;

	typedef enum logic [1:0] {
		CFG_SAMPLE_RATE = 2'd0,
		CFG_Q_FACTOR    = 2'd1,
		CFG_NORMALIZE   = 2'd2
	} cfg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PH_LOAD,
		S_PH_RUN,
		S_ZMUL,
		S_COR_RUN,
		S_AL_LOAD,
		S_AL_RUN,
		S_COEF,
		S_NRM_LOAD,
		S_NRM_RUN,
		S_NRM_SAVE,
		S_DONE
	} state_t;

	typedef enum logic [2:0] {
		DIV_PHASE,
		DIV_ALPHA,
		DIV_B0,
		DIV_B1,
		DIV_A1,
		DIV_A2
	} div_sel_t;

	typedef struct packed {
		logic     capture;
		logic     div_load;
		div_sel_t div_sel;
		logic     div_step;
		logic     cor_init;
		logic     cor_step;
		logic     coef_latch;
		logic     norm_latch;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic div_last;
		logic cor_last;
		logic normalize;
		logic out_free;
	} stat_t;

	function automatic logic signed [CS_W-1:0] atan_q30(input logic [COR_CW-1:0] i);
		logic [31:0] t;
		begin
			case (i)
				0: t = 32'h3243F6A8;   1: t = 32'h1DAC6705;   2: t = 32'h0FADBAFC;
				3: t = 32'h07F56EA6;   4: t = 32'h03FEAB76;   5: t = 32'h01FFD55B;
				6: t = 32'h00FFFAAA;   7: t = 32'h007FFF55;   8: t = 32'h003FFFEA;
				9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF;  11: t = 32'h0007FFFF;
				12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF;  14: t = 32'h0000FFFF;
				15: t = 32'h00007FFF; 16: t = 32'h00003FFF;  17: t = 32'h00001FFF;
				18: t = 32'h00000FFF; 19: t = 32'h000007FF;  20: t = 32'h000003FF;
				21: t = 32'h000001FF; 22: t = 32'h000000FF;  23: t = 32'h0000007F;
				24: t = 32'h0000003F; 25: t = 32'h0000001F;  26: t = 32'h0000000F;
				27: t = 32'h00000008; 28: t = 32'h00000004;  29: t = 32'h00000002;
				30: t = 32'h00000001;
				default: t = 32'h00000000;
			endcase
			return signed'({2'b00, t});
		end
	endfunction

	function automatic logic [31:0] sat_pack(input logic signed [64:0] v);
		logic signed [64:0] hi;
		logic signed [64:0] lo;
		logic signed [64:0] r;
		begin
			hi = (65'sd1 <<< (COEF_WIDTH - 1)) - 65'sd1;
			lo = -hi - 65'sd1;
			if (v > hi) begin
				r = hi;
			end else if (v < lo) begin
				r = lo;
			end else begin
				r = v;
			end
			return r[31:0];
		end
	endfunction

endpackage

// File: design/lpbq_ctrl.sv
// Sequencing state machine of the lowpass biquad coefficient calculator.
module lpbq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lpbq_pkg::stat_t stat,
	output lpbq_pkg::cmd_t  cmd
);

	lpbq_pkg::state_t   state_q, state_d;
	lpbq_pkg::div_sel_t sel_q, sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpbq_pkg::S_IDLE;
			sel_q   <= lpbq_pkg::DIV_B0;
		end else begin
			state_q <= state_d;
			sel_q   <= sel_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		sel_d       = sel_q;
		cmd         = '0;
		cmd.div_sel = sel_q;
		in_ready    = 1'b0;
		case (state_q)
			lpbq_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (!stat.reject) begin
						state_d = lpbq_pkg::S_PH_LOAD;
					end
				end
			end
			lpbq_pkg::S_PH_LOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = lpbq_pkg::DIV_PHASE;
				state_d      = lpbq_pkg::S_PH_RUN;
			end
			lpbq_pkg::S_PH_RUN: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = lpbq_pkg::S_ZMUL;
				end
			end
			lpbq_pkg::S_ZMUL: begin
				cmd.cor_init = 1'b1;
				state_d      = lpbq_pkg::S_COR_RUN;
			end
			lpbq_pkg::S_COR_RUN: begin
				cmd.cor_step = 1'b1;
				if (stat.cor_last) begin
					state_d = lpbq_pkg::S_AL_LOAD;
				end
			end
			lpbq_pkg::S_AL_LOAD: begin
				cmd.div_load = 1'b1;
				cmd.div_sel  = lpbq_pkg::DIV_ALPHA;
				state_d      = lpbq_pkg::S_AL_RUN;
			end
			lpbq_pkg::S_AL_RUN: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = lpbq_pkg::S_COEF;
				end
			end
			lpbq_pkg::S_COEF: begin
				cmd.coef_latch = 1'b1;
				sel_d          = lpbq_pkg::DIV_B0;
				state_d        = stat.normalize ? lpbq_pkg::S_NRM_LOAD : lpbq_pkg::S_DONE;
			end
			lpbq_pkg::S_NRM_LOAD: begin
				cmd.div_load = 1'b1;
				state_d      = lpbq_pkg::S_NRM_RUN;
			end
			lpbq_pkg::S_NRM_RUN: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = lpbq_pkg::S_NRM_SAVE;
				end
			end
			lpbq_pkg::S_NRM_SAVE: begin
				cmd.norm_latch = 1'b1;
				state_d        = lpbq_pkg::S_NRM_LOAD;
				case (sel_q)
					lpbq_pkg::DIV_B0: sel_d = lpbq_pkg::DIV_B1;
					lpbq_pkg::DIV_B1: sel_d = lpbq_pkg::DIV_A1;
					lpbq_pkg::DIV_A1: sel_d = lpbq_pkg::DIV_A2;
					default:          state_d = lpbq_pkg::S_DONE;
				endcase
			end
			lpbq_pkg::S_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = lpbq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lpbq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: design/lpbq_dp.sv
// Datapath of the lowpass biquad coefficient calculator: registers, divider, CORDIC, outputs.
module lpbq_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic [1:0]            cfg_index,
	input  logic [22:0]           cfg_data,
	input  logic                  mode,
	input  logic [20:0]           cutoff_freq,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [31:0]           coef_b0,
	output logic [31:0]           coef_b1,
	output logic [31:0]           coef_b2,
	output logic [31:0]           coef_a0,
	output logic [31:0]           coef_a1,
	output logic [31:0]           coef_a2,
	output logic                  is_normalized,
	input  lpbq_pkg::cmd_t        cmd,
	output lpbq_pkg::stat_t       stat
);

	localparam int VW = lpbq_pkg::VAL_W;
	localparam int CW = lpbq_pkg::CS_W;

	logic [17:0] fs_q;
	logic [22:0] q_q;
	logic        norm_q;
	logic [20:0] cut_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_q   <= lpbq_pkg::RST_FS;
			q_q    <= lpbq_pkg::RST_Q;
			norm_q <= lpbq_pkg::RST_NORM;
			cut_q  <= lpbq_pkg::MIN_CUTOFF;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					lpbq_pkg::CFG_SAMPLE_RATE: fs_q   <= cfg_data[17:0];
					lpbq_pkg::CFG_Q_FACTOR:    q_q    <= cfg_data;
					lpbq_pkg::CFG_NORMALIZE:   norm_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.capture && mode && !stat.reject) begin
				cut_q <= cutoff_freq;
			end
		end
	end

	// divider
	logic [lpbq_pkg::DIV_W-1:0]  quo_q;
	logic [lpbq_pkg::DSR_W-1:0]  rem_q;
	logic [lpbq_pkg::DSR_W-1:0]  dsr_q;
	logic                        neg_q;
	logic [lpbq_pkg::DIV_CW-1:0] dcnt_q;
	logic [lpbq_pkg::DIV_W-1:0]  dvd_d;
	logic [lpbq_pkg::DSR_W-1:0]  dsr_d;
	logic                        neg_d;
	logic [lpbq_pkg::DSR_W:0]    trial;

	// CORDIC
	logic signed [CW-1:0]        x_q, y_q, z_q;
	logic [lpbq_pkg::COR_CW-1:0] ccnt_q;
	logic [1:0]                  quad_q;
	logic signed [CW-1:0]        c_v, s_v, dx, dy, at;
	logic [CW-1:0]               s_abs;

	logic signed [VW-1:0] b0_q, b1_q, a0_q, a1_q, a2_q;
	logic signed [VW-1:0] nv;
	logic [VW-1:0]        nv_abs, a0_abs;
	logic [31:0]          nb0_q, nb1_q, na1_q, na2_q;
	logic signed [64:0]   qs;
	logic [29:0]          r_v;
	logic [61:0]          prod;

	logic signed [VW-1:0] c_x, alpha_v, b1_v;
	logic [lpbq_pkg::DIV_W-1:0] amag;

	always_comb begin
		case (quad_q)
			2'd0: begin c_v = x_q;  s_v = y_q;  end
			2'd1: begin c_v = -y_q; s_v = x_q;  end
			2'd2: begin c_v = -x_q; s_v = -y_q; end
			default: begin c_v = y_q; s_v = -x_q; end
		endcase
		s_abs  = s_v[CW-1] ? unsigned'(-s_v) : unsigned'(s_v);
		a0_abs = a0_q[VW-1] ? unsigned'(-a0_q) : unsigned'(a0_q);
		case (cmd.div_sel)
			lpbq_pkg::DIV_B0: nv = b0_q;
			lpbq_pkg::DIV_B1: nv = b1_q;
			lpbq_pkg::DIV_A1: nv = a1_q;
			default:          nv = a2_q;
		endcase
		nv_abs = nv[VW-1] ? unsigned'(-nv) : unsigned'(nv);
		case (cmd.div_sel)
			lpbq_pkg::DIV_PHASE: begin
				dvd_d = {15'd0, cut_q, 28'd0};
				dsr_d = {22'd0, fs_q};
				neg_d = 1'b0;
			end
			lpbq_pkg::DIV_ALPHA: begin
				dvd_d = {15'd0, s_abs, 15'd0};
				dsr_d = (q_q == 23'd0) ? 40'd1 : {17'd0, q_q};
				neg_d = s_v[CW-1];
			end
			default: begin
				dvd_d = {nv_abs[39:0], 24'd0};
				dsr_d = (a0_abs == '0) ? 40'd1 : a0_abs[39:0];
				neg_d = nv[VW-1] ^ a0_q[VW-1];
			end
		endcase
		trial = {rem_q, quo_q[lpbq_pkg::DIV_W-1]};
		qs    = neg_q ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
		dx    = y_q >>> ccnt_q;
		dy    = x_q >>> ccnt_q;
		at    = lpbq_pkg::atan_q30(ccnt_q);
		r_v   = (fs_q == 18'd0) ? 30'd0 : quo_q[29:0];
		prod  = 62'(r_v) * 62'(lpbq_pkg::PI_Q30);
		amag  = (quo_q > lpbq_pkg::ALPHA_LIMIT) ? lpbq_pkg::ALPHA_LIMIT : quo_q;
		alpha_v = neg_q ? -signed'(amag[VW-1:0]) : signed'(amag[VW-1:0]);
		c_x   = VW'(c_v);
		b1_v  = lpbq_pkg::ONE_Q30 - c_x;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q <= dvd_d;
			rem_q <= '0;
			dsr_q <= dsr_d;
			neg_q <= neg_d;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= lpbq_pkg::DSR_W'(trial - {1'b0, dsr_q});
				quo_q <= {quo_q[lpbq_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[lpbq_pkg::DSR_W-1:0];
				quo_q <= {quo_q[lpbq_pkg::DIV_W-2:0], 1'b0};
			end
		end
		if (cmd.cor_init) begin
			x_q    <= lpbq_pkg::CORDIC_GAIN;
			y_q    <= '0;
			z_q    <= signed'({3'b000, prod[61:31]});
			quad_q <= (fs_q == 18'd0) ? 2'd0 : quo_q[31:30];
		end else if (cmd.cor_step) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
		if (cmd.coef_latch) begin
			b1_q <= b1_v;
			b0_q <= b1_v >>> 1;
			a0_q <= lpbq_pkg::ONE_Q30 + alpha_v;
			a1_q <= -(c_x <<< 1);
			a2_q <= lpbq_pkg::ONE_Q30 - alpha_v;
		end
		if (cmd.norm_latch) begin
			case (cmd.div_sel)
				lpbq_pkg::DIV_B0: nb0_q <= lpbq_pkg::sat_pack(qs);
				lpbq_pkg::DIV_B1: nb1_q <= lpbq_pkg::sat_pack(qs);
				lpbq_pkg::DIV_A1: na1_q <= lpbq_pkg::sat_pack(qs);
				default:          na2_q <= lpbq_pkg::sat_pack(qs);
			endcase
		end
		if (cmd.out_load) begin
			is_normalized <= norm_q;
			if (norm_q) begin
				coef_b0 <= nb0_q;
				coef_b1 <= nb1_q;
				coef_b2 <= nb0_q;
				coef_a0 <= lpbq_pkg::sat_pack(lpbq_pkg::UNITY_Q24);
				coef_a1 <= na1_q;
				coef_a2 <= na2_q;
			end else begin
				coef_b0 <= lpbq_pkg::sat_pack(65'(b0_q) >>> 6);
				coef_b1 <= lpbq_pkg::sat_pack(65'(b1_q) >>> 6);
				coef_b2 <= lpbq_pkg::sat_pack(65'(b0_q) >>> 6);
				coef_a0 <= lpbq_pkg::sat_pack(65'(a0_q) >>> 6);
				coef_a1 <= lpbq_pkg::sat_pack(65'(a1_q) >>> 6);
				coef_a2 <= lpbq_pkg::sat_pack(65'(a2_q) >>> 6);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q    <= '0;
			ccnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.div_load) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.cor_init) begin
				ccnt_q <= '0;
			end else if (cmd.cor_step) begin
				ccnt_q <= ccnt_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	assign stat.reject    = mode && ((cutoff_freq < lpbq_pkg::MIN_CUTOFF) ||
	                                 (cutoff_freq > {fs_q, 3'b000}));
	assign stat.div_last  = (dcnt_q == lpbq_pkg::DIV_CW'(lpbq_pkg::DIV_STEPS - 1));
	assign stat.cor_last  = (ccnt_q == lpbq_pkg::COR_CW'(lpbq_pkg::CORDIC_STEPS - 1));
	assign stat.normalize = norm_q;
	assign stat.out_free  = !out_valid || out_ready;

endmodule

// File: design/lowpass_biquad_coefficient_calc_top.sv
// Lowpass biquad coefficient calculator (cookbook lowpass) top level.
//
// Input channel in_valid/in_ready carries mode and cutoff_freq (1/16 Hz).
// Mode 1 stores a new cutoff and computes; an out-of-range cutoff is taken
// and dropped with no result. Mode 0 recomputes from the stored cutoff.
// The config channel cfg_valid/cfg_ready is always ready: index 0 sample
// rate, 1 Q factor (Q7.16), 2 normalize; write only while the block is idle.
// Output channel out_valid/out_ready gives b0, b1, b2, a0, a1, a2 (Q8.24)
// and is_normalized.
// One shared 64-step restoring divider does the phase and alpha divisions
// and, when normalizing, four divisions by a0 with a store step each; the
// phase and alpha divisions are separated by 24 CORDIC iterations. One item
// is worked at a time: in_ready is high only while idle, so a new item is
// not taken before the last result is loaded into the output register.
// A finished result waits in the output register while the receiver stalls;
// the next item may be accepted meanwhile and its result is held back until
// the register is free.
// Reset restores sample rate 48000, Q 0.7071, normalize on, cutoff 20 Hz.
module lowpass_biquad_coefficient_calc_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [20:0] cutoff_freq,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] coef_b0,
	output logic [31:0] coef_b1,
	output logic [31:0] coef_b2,
	output logic [31:0] coef_a0,
	output logic [31:0] coef_a1,
	output logic [31:0] coef_a2,
	output logic        is_normalized
);

	lpbq_pkg::cmd_t  cmd;
	lpbq_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	lpbq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lpbq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mode          (mode),
		.cutoff_freq   (cutoff_freq),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.coef_b0       (coef_b0),
		.coef_b1       (coef_b1),
		.coef_b2       (coef_b2),
		.coef_a0       (coef_a0),
		.coef_a1       (coef_a1),
		.coef_a2       (coef_a2),
		.is_normalized (is_normalized),
		.cmd           (cmd),
		.stat          (stat)
	);

endmodule

// File: design/lpbq_checker.sv
// Port-level checker of the lowpass biquad coefficient calculator and its bind.
module lpbq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] coef_b0,
	input logic [31:0] coef_b2,
	input logic [31:0] coef_a0,
	input logic        is_normalized
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared right after accept");

	a_b2_eq_b0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> coef_b2 == coef_b0)
		else $error("b2 differs from b0");

	a_norm_a0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_normalized |-> coef_a0 == 32'h0100_0000)
		else $error("normalized a0 is not unity");

endmodule

bind lowpass_biquad_coefficient_calc_top lpbq_checker u_lpbq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.coef_b0       (coef_b0),
	.coef_b2       (coef_b2),
	.coef_a0       (coef_a0),
	.is_normalized (is_normalized)
);
